[hdl/hfd_pkg.sv]
`timescale 1ns / 1ps

package hfd_pkg;

  // sample line geometry
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DEPTH    = 1 << ADDR_W;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned WHOLE_W  = 16;

  // largest whole delay that still leaves two older neighbours
  localparam logic [WHOLE_W-1:0] MAX_WHOLE = WHOLE_W'(DEPTH - 3);

  // interpolator arithmetic widths
  localparam int unsigned COEF_W = 28;
  localparam int unsigned ACC_W  = 30;
  localparam int unsigned PROD_W = ACC_W + FRAC_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 1;

  // neighbour reads per item: four for each of two taps
  localparam int unsigned RD_CNT = 8;
  localparam int unsigned RD_W   = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [FRAC_W-1:0]          frac_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CALC = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

endpackage

[hdl/hermite_fractional_delay.sv]
`timescale 1ns / 1ps
// sequence: eight neighbour reads through the single read port of the sample
//   memory, then three multiply/round steps; a new input is accepted only after
//   the previous result is loaded into the output register, so a held output
//   delays the next input transfer
// reset: write pointer and control clear at once; entries not yet written read
//   as zero through the write pointer and a wrap flag, so no clearing pass

module hermite_fractional_delay import hfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sample_t            sample_in_i,
  input  logic [WHOLE_W-1:0] delay_a_whole_i,
  input  frac_t              delay_a_frac_i,
  input  logic [WHOLE_W-1:0] delay_b_whole_i,
  input  frac_t              delay_b_frac_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sample_t            tap_a_o,
  output sample_t            tap_b_o
);

  localparam logic [RD_W-1:0] LAST_RD = RD_W'(RD_CNT - 1);

  state_e             state_q, state_d;
  addr_t              wp_q, cur_wp_q;
  logic               full_q;
  addr_t              base_q [2];
  frac_t              frac_q [2];
  logic [RD_W-1:0]    rd_cnt_q;
  logic               rd_vld_q, rd_zero_q;
  logic [RD_W-1:0]    rd_idx_q;
  sample_t            rdata_q;
  sample_t            samp_q [RD_CNT];
  logic               start_q;
  logic               out_valid_q;
  sample_t            tap_a_q, tap_b_q;
  sample_t            mem_q [DEPTH];

  logic               in_xfer, out_load;
  logic               rd_en;
  addr_t              raddr;
  logic [WHOLE_W-1:0] da, db;
  logic               done_a, done_b;
  sample_t            y_a, y_b;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign rd_en      = (state_q == ST_READ);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // clamp whole delays
  assign da = (delay_a_whole_i > MAX_WHOLE) ? MAX_WHOLE : delay_a_whole_i;
  assign db = (delay_b_whole_i > MAX_WHOLE) ? MAX_WHOLE : delay_b_whole_i;

  // neighbour address: base+1, base, base-1, base-2 for each tap
  assign raddr = base_q[rd_cnt_q[2]] + ADDR_W'(1) - ADDR_W'(rd_cnt_q[1:0]);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_READ;
      ST_READ: if (rd_cnt_q == LAST_RD) state_d = ST_CALC;
      ST_CALC: if (done_a && done_b) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      full_q      <= 1'b0;
      rd_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      start_q  <= rd_vld_q && (rd_idx_q == LAST_RD);
      if (in_xfer) begin
        wp_q <= wp_q + ADDR_W'(1);
        if (wp_q == '1) full_q <= 1'b1;
      end
      if (in_xfer) begin
        rd_cnt_q <= '0;
      end else if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + RD_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item registers taken at the input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cur_wp_q  <= wp_q;
      base_q[0] <= wp_q - ADDR_W'(da);
      base_q[1] <= wp_q - ADDR_W'(db);
      frac_q[0] <= delay_a_frac_i;
      frac_q[1] <= delay_b_frac_i;
    end
  end

  // sample memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_xfer) mem_q[wp_q] <= sample_in_i;
    rdata_q <= mem_q[raddr];
  end

  // entries never written read as zero
  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_cnt_q;
    rd_zero_q <= !(full_q || (raddr <= cur_wp_q));
    if (rd_vld_q) samp_q[rd_idx_q] <= rd_zero_q ? sample_t'(0) : rdata_q;
  end

  hfd_interp u_interp_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .v0_i    (samp_q[0]),
    .v1_i    (samp_q[1]),
    .v2_i    (samp_q[2]),
    .v3_i    (samp_q[3]),
    .x_i     (frac_q[0]),
    .done_o  (done_a),
    .y_o     (y_a)
  );

  hfd_interp u_interp_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .v0_i    (samp_q[4]),
    .v1_i    (samp_q[5]),
    .v2_i    (samp_q[6]),
    .v3_i    (samp_q[7]),
    .x_i     (frac_q[1]),
    .done_o  (done_b),
    .y_o     (y_b)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      tap_a_q <= y_a;
      tap_b_q <= y_b;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tap_a_o     = tap_a_q;
  assign tap_b_o     = tap_b_q;

endmodule

[hdl/hfd_interp.sv]
`timescale 1ns / 1ps

module hfd_interp import hfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  sample_t v0_i,
  input  sample_t v1_i,
  input  sample_t v2_i,
  input  sample_t v3_i,
  input  frac_t   x_i,
  output logic    done_o,
  output sample_t y_o
);

  localparam logic [2:0] PH_LAST = 3'd5;
  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] Y_MIN = -ACC_W'(1 << (SAMPLE_W - 1));

  logic                     busy_q, busy_d;
  logic [2:0]               ph_q, ph_d;
  logic                     done_q, done_d;
  logic signed [COEF_W-1:0] c1_q, c2_q, v1x2_q;
  logic signed [COEF_W-1:0] c1_d, c2_d, c3_d, v1x2_d;
  logic signed [ACC_W-1:0]  h_q, h_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [COEF_W-1:0] e0, e1, e2, e3, addend;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  rnd16, rnd17;

  // doubled catmull-rom coefficients
  always_comb begin
    e0 = COEF_W'(v0_i);
    e1 = COEF_W'(v1_i);
    e2 = COEF_W'(v2_i);
    e3 = COEF_W'(v3_i);
    c1_d   = e2 - e0;
    c2_d   = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    c3_d   = ((e1 - e2) <<< 1) + (e1 - e2) + (e3 - e0);
    v1x2_d = e1 <<< 1;
  end

  // horner step: multiply on even phases, add and round on odd phases
  always_comb begin
    case (ph_q[2:1])
      2'd0:    addend = c2_q;
      2'd1:    addend = c1_q;
      default: addend = v1x2_q;
    endcase
    sum   = SUM_W'(prod_q) + (SUM_W'(addend) <<< FRAC_W);
    rnd16 = (sum + SUM_W'(1 << (FRAC_W - 1))) >>> FRAC_W;
    rnd17 = (sum + SUM_W'(1 << FRAC_W)) >>> (FRAC_W + 1);
  end

  always_comb begin
    busy_d = busy_q;
    ph_d   = ph_q;
    h_d    = h_q;
    prod_d = prod_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      ph_d   = '0;
      h_d    = ACC_W'(c3_d);
    end else if (busy_q) begin
      ph_d = ph_q + 3'd1;
      if (!ph_q[0]) begin
        prod_d = PROD_W'(h_q) * $signed({1'b0, x_i});
      end else if (ph_q == PH_LAST) begin
        h_d    = ACC_W'(rnd17);
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        h_d = ACC_W'(rnd16);
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      c1_q   <= c1_d;
      c2_q   <= c2_d;
      v1x2_q <= v1x2_d;
    end
    h_q    <= h_d;
    prod_q <= prod_d;
  end

  // saturate to the sample range
  always_comb begin
    if (h_q > Y_MAX) begin
      y_o = SAMPLE_W'(Y_MAX);
    end else if (h_q < Y_MIN) begin
      y_o = SAMPLE_W'(Y_MIN);
    end else begin
      y_o = SAMPLE_W'(h_q);
    end
  end

  assign done_o = done_q;

endmodule
